>>> design/cvkb_pkg.sv
// Shared types and constants for the console text and key queue I/O block.
package cvkb_pkg;

	localparam int TEXT_BYTES_DEF = 40;
	localparam int KEY_DEPTH_DEF  = 8;

	localparam int TEXT_BASE  = 40;
	localparam int QUEUE_BASE = 24;

	localparam logic [7:0] BLANK = 8'h20;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_KEY   = 2'd2
	} kind_t;

	typedef struct packed {
		logic       pop;
		logic       push;
		logic [7:0] code;
	} key_op_t;

endpackage

>>> design/console_video_and_key_buffer_io_unit.sv
// Top level of the console text and key queue I/O block.
//
// Input channel (in_valid/in_ready) carries one item per transfer: kind selects a
// bus write, a bus read or a keypress; addr and data go with it. Only bus reads
// produce a result, which leaves on the output channel (out_valid/out_ready) as
// read_data. Writes, keypresses and kind 3 produce nothing.
// Throughput: one item per cycle, but a read waits while the output register holds a stalled result.
// Read path: a read passes the input register, then lands in the output register with the
// registered read port of the text store; with out_ready high it leaves at the next edge.
// Text bytes live at addr 40 and up, key queue entries at 24 and up; a write to
// 24 pops the queue. Unmapped reads return 0.
// Reset: the key queue clears to zero at once and every text byte reads as a
// space until written; no clearing pass, items are taken right after reset.
// Receiver stall: the read result holds in the output register; a following read
// waits in the input register and holds off the input until the result leaves.
module console_video_and_key_buffer_io_unit
	import cvkb_pkg::*;
#(
	parameter int TEXT_BYTES = TEXT_BYTES_DEF,
	parameter int KEY_DEPTH  = KEY_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [7:0] addr,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);

	localparam int TW       = (TEXT_BYTES > 1) ? $clog2(TEXT_BYTES) : 1;
	localparam int KW       = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int TEXT_END = TEXT_BASE + TEXT_BYTES;
	localparam int KEY_END  = QUEUE_BASE + KEY_DEPTH;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] addr_s1;
	logic [7:0] data_s1;

	logic       vld_s2;
	logic       sel_mem_s2;
	logic [7:0] alt_s2;

	logic       out_free;
	logic       fire_s1;
	logic       is_read;
	logic       is_write;
	logic       is_key;
	logic       in_text;
	logic       in_queue;
	logic [7:0] text_off;
	logic [7:0] key_off;
	logic [7:0] text_rdata;
	logic [7:0] key_rdata;
	key_op_t    key_op;

	assign is_read  = (kind_s1 == KIND_READ);
	assign is_write = (kind_s1 == KIND_WRITE);
	assign is_key   = (kind_s1 == KIND_KEY);

	assign in_text  = ({1'b0, addr_s1} >= 9'(TEXT_BASE)) && ({1'b0, addr_s1} < 9'(TEXT_END));
	assign in_queue = ({1'b0, addr_s1} >= 9'(QUEUE_BASE)) && ({1'b0, addr_s1} < 9'(KEY_END));
	assign text_off = addr_s1 - 8'(TEXT_BASE);
	assign key_off  = addr_s1 - 8'(QUEUE_BASE);

	// A read needs the output register free; other kinds never wait.
	assign out_free = !vld_s2 || out_ready;
	assign fire_s1  = valid_s1 && (!is_read || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			addr_s1 <= addr;
			data_s1 <= data;
		end
	end

	always_comb begin
		key_op      = '0;
		key_op.pop  = fire_s1 && is_write && !in_text && (addr_s1 == 8'(QUEUE_BASE));
		key_op.push = fire_s1 && is_key;
		key_op.code = data_s1;
	end

	cvkb_text_mem #(
		.DEPTH (TEXT_BYTES)
	) u_text (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (fire_s1 && is_write && in_text),
		.waddr  (text_off[TW-1:0]),
		.wdata  (data_s1),
		.re     (fire_s1 && is_read && in_text),
		.raddr  (text_off[TW-1:0]),
		.rdata  (text_rdata)
	);

	cvkb_key_queue #(
		.DEPTH (KEY_DEPTH)
	) u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (key_op),
		.raddr  (key_off[KW-1:0]),
		.rdata  (key_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (fire_s1 && is_read) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_read) begin
			sel_mem_s2 <= in_text;
			alt_s2     <= in_queue ? key_rdata : 8'd0;
		end
	end

	assign out_valid = vld_s2;
	assign read_data = sel_mem_s2 ? text_rdata : alt_s2;

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && is_read) |=> vld_s2)
		else $error("read transfer did not reach the output register");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !out_ready) |=> $stable(read_data))
		else $error("stalled read result changed");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_read && vld_s2 && !out_ready) |-> !in_ready)
		else $error("input taken while a read waits for the output register");

endmodule

>>> design/cvkb_text_mem.sv
// Console text store: one write port, one registered read port, per-byte written flags.
module cvkb_text_mem
	import cvkb_pkg::*;
#(
	parameter int DEPTH = TEXT_BYTES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [7:0]                             wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [7:0]                             rdata
);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	logic [7:0]       rd_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q  <= mem[raddr];
			hit_q <= written_q[raddr];
		end
	end

	// Bytes never written read back as blanks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	assign rdata = hit_q ? rd_q : BLANK;

endmodule

>>> design/cvkb_key_queue.sv
// Key queue: parallel pop shift and first-empty-slot insert.
module cvkb_key_queue
	import cvkb_pkg::*;
#(
	parameter int DEPTH = KEY_DEPTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  key_op_t                                     op,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [7:0]                                  rdata
);

	logic [DEPTH-1:0][7:0] q_q;
	logic [DEPTH-1:0][7:0] q_nxt;
	logic                  full;
	logic                  found;

	always_comb begin
		q_nxt = q_q;
		found = 1'b0;
		if (op.pop) begin
			for (int k = 0; k < DEPTH - 1; k++) begin
				q_nxt[k] = q_q[k+1];
			end
			q_nxt[DEPTH-1] = 8'd0;
		end else if (op.push) begin
			// Fill the lowest empty slot; drop the code if none is empty.
			for (int k = 0; k < DEPTH; k++) begin
				if (!found && q_q[k] == 8'd0) begin
					q_nxt[k] = op.code;
					found    = 1'b1;
				end
			end
		end
	end

	always_comb begin
		full = 1'b1;
		for (int k = 0; k < DEPTH; k++) begin
			if (q_q[k] == 8'd0) begin
				full = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
		end else begin
			q_q <= q_nxt;
		end
	end

	assign rdata = q_q[raddr];

	a_pop_clears_top: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |=> q_q[DEPTH-1] == 8'd0)
		else $error("key queue top not cleared after pop");

	a_full_drops_key: assert property (@(posedge clk) disable iff (!arst_n)
		(op.push && !op.pop && full) |=> $stable(q_q))
		else $error("key queue changed on push while full");

endmodule

>>> dv/console_video_and_key_buffer_io_unit_test.sv
// Testbench for the console text and key queue I/O unit: table-driven and random bus traffic.
`timescale 1ns / 100ps

module console_video_and_key_buffer_io_unit_test;
	import cvkb_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int DIRECTED_ROWS = 25;
	localparam int RANDOM_ITEMS = 1700;
	localparam int SEGMENT_ITEMS = 150;
	localparam int PAUSE_AT = 1300;
	localparam int LONG_HOLD_AT = 150;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 8;
	localparam int RUN_LIMIT_NS = 4_000_000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] addr;
		logic [7:0] data;
		logic       fixed;
		logic [7:0] value;
	} access_row_t;

	// Rows with fixed set carry a hand-read expectation; the rest use the predictor.
	access_row_t directed_rows [DIRECTED_ROWS] = '{
		'{KIND_READ,   8'd40,  8'h00, 1'b1, BLANK},
		'{KIND_READ,   8'd79,  8'h00, 1'b1, BLANK},
		'{KIND_READ,   8'd24,  8'h00, 1'b1, 8'h00},
		'{KIND_READ,   8'd31,  8'h00, 1'b1, 8'h00},
		'{KIND_READ,   8'd0,   8'h00, 1'b1, 8'h00},
		'{KIND_READ,   8'd255, 8'hff, 1'b1, 8'h00},
		'{KIND_WRITE,  8'd40,  8'hff, 1'b0, 8'h00},
		'{KIND_WRITE,  8'd79,  8'h00, 1'b0, 8'h00},
		'{KIND_READ,   8'd40,  8'h00, 1'b0, 8'h00},
		'{KIND_READ,   8'd79,  8'h00, 1'b0, 8'h00},
		'{KIND_WRITE,  8'd200, 8'h55, 1'b0, 8'h00},
		'{KIND_UNUSED, 8'd40,  8'haa, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h00, 1'b0, 8'h00},
		'{KIND_KEY,    8'd255, 8'hff, 1'b0, 8'h00},
		'{KIND_KEY,    8'd24,  8'h01, 1'b0, 8'h00},
		'{KIND_KEY,    8'd40,  8'h02, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h80, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h7f, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h55, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'haa, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h33, 1'b0, 8'h00},
		'{KIND_KEY,    8'd0,   8'h77, 1'b0, 8'h00},
		'{KIND_READ,   8'd31,  8'h00, 1'b0, 8'h00},
		'{KIND_WRITE,  8'd24,  8'h00, 1'b0, 8'h00},
		'{KIND_READ,   8'd24,  8'h00, 1'b0, 8'h00}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = KIND_WRITE;
	logic [7:0] addr = 8'h00;
	logic [7:0] data = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;

	logic [7:0] shadow_text [TEXT_BYTES_DEF];
	logic [7:0] shadow_keys [KEY_DEPTH_DEF];
	logic [7:0] pending_reads [$];
	logic [7:0] want;
	bit         sender_burst = 1'b0;
	int unsigned mismatches = 0;
	int unsigned reads_checked = 0;
	int unsigned items_sent = 0;
	int unsigned pops_done = 0;
	int unsigned keys_stored = 0;
	int unsigned keys_dropped = 0;

	console_video_and_key_buffer_io_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.addr      (addr),
		.data      (data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout with %0d reads still pending", pending_reads.size());
		$display("status: fail");
		$finish;
	end

	function automatic bit in_text(input logic [7:0] a);
		return a >= TEXT_BASE && a < TEXT_BASE + TEXT_BYTES_DEF;
	endfunction

	// Update the shadow text and key queue for one access; return the bus read value.
	task automatic predict_access(input logic [1:0] k, input logic [7:0] a,
			input logic [7:0] d, output bit has_result, output logic [7:0] value);
		bit placed;
		has_result = 1'b0;
		value = 8'h00;
		placed = 1'b0;
		case (k)
		KIND_WRITE: begin
			if (in_text(a)) begin
				shadow_text[a - TEXT_BASE] = d;
			end else if (a == QUEUE_BASE) begin
				for (int i = 0; i + 1 < KEY_DEPTH_DEF; i++)
					shadow_keys[i] = shadow_keys[i + 1];
				shadow_keys[KEY_DEPTH_DEF - 1] = 8'h00;
				pops_done++;
			end
		end
		KIND_READ: begin
			has_result = 1'b1;
			if (in_text(a))
				value = shadow_text[a - TEXT_BASE];
			else if (a >= QUEUE_BASE && a < QUEUE_BASE + KEY_DEPTH_DEF)
				value = shadow_keys[a - QUEUE_BASE];
		end
		KIND_KEY: begin
			for (int i = 0; i < KEY_DEPTH_DEF; i++) begin
				if (!placed && shadow_keys[i] == 8'h00) begin
					shadow_keys[i] = d;
					placed = 1'b1;
				end
			end
			if (!placed)
				keys_dropped++;
			else if (d != 8'h00)
				keys_stored++;
		end
		default: ;
		endcase
	endtask

	// Present one item after a random gap (none in a sender burst) and hold it until the transfer.
	task automatic offer_item(input logic [1:0] k, input logic [7:0] a, input logic [7:0] d,
			input bit fixed, input logic [7:0] fixed_value);
		int unsigned gap;
		bit has_result;
		logic [7:0] value;
		gap = sender_burst ? 0 : $urandom_range(9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		addr <= a;
		data <= d;
		do @(posedge clk); while (!in_ready);
		predict_access(k, a, d, has_result, value);
		if (has_result)
			pending_reads.push_back(fixed ? fixed_value : value);
		items_sent++;
	endtask

	function automatic logic [7:0] random_addr();
		case ($urandom_range(9))
		0, 1, 2, 3, 4: return 8'(TEXT_BASE + $urandom_range(TEXT_BYTES_DEF - 1));
		5, 6: return 8'(QUEUE_BASE + $urandom_range(KEY_DEPTH_DEF - 1));
		7: return 8'(QUEUE_BASE);
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Receiver: random stall per result, one long hold-off to back up the input.
	initial begin
		int unsigned hold;
		int unsigned taken;
		bit burst;
		taken = 0;
		burst = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				burst = ($urandom_range(3) == 0);
			if (taken == LONG_HOLD_AT)
				hold = LONG_HOLD_CYCLES;
			else
				hold = burst ? 0 : $urandom_range(9);
			if (hold != 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("read_data %02h arrived with no read pending", read_data);
			end else begin
				want = pending_reads.pop_front();
				reads_checked++;
				if (read_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read_data mismatch: expected %02h, got %02h", want, read_data);
				end
			end
		end
	end

	initial begin
		int unsigned counted;
		int unsigned n;
		int unsigned sel;
		int unsigned leftover;
		logic [1:0] k;
		logic [7:0] a;
		logic [7:0] d;
		bit pop_heavy;
		bit paused;
		for (int i = 0; i < TEXT_BYTES_DEF; i++)
			shadow_text[i] = BLANK;
		for (int i = 0; i < KEY_DEPTH_DEF; i++)
			shadow_keys[i] = 8'h00;
		counted = 0;
		n = 0;
		pop_heavy = 1'b0;
		paused = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			offer_item(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].data,
				directed_rows[i].fixed, directed_rows[i].value);

		while (counted < RANDOM_ITEMS) begin
			if (n % SEGMENT_ITEMS == 0) begin
				pop_heavy = 1'($urandom_range(1));
				sender_burst = ($urandom_range(3) == 0);
			end
			if (counted == PAUSE_AT && !paused) begin
				// Drain everything before carrying on.
				paused = 1'b1;
				in_valid <= 1'b0;
				while (pending_reads.size() != 0) @(posedge clk);
			end
			sel = $urandom_range(99);
			d = 8'($urandom_range(255));
			if (sel < 34) begin
				k = KIND_READ;
				a = random_addr();
			end else if (sel < 64) begin
				k = KIND_WRITE;
				a = (pop_heavy && $urandom_range(1)) ? 8'(QUEUE_BASE) : random_addr();
			end else if (sel < 95) begin
				k = KIND_KEY;
				a = 8'($urandom_range(255));
				if ($urandom_range(15) == 0)
					d = 8'h00;
				// In pop-heavy segments, turn about half the keypresses into pops so the queue drains.
				if (pop_heavy && $urandom_range(1)) begin
					k = KIND_WRITE;
					a = 8'(QUEUE_BASE);
				end
			end else begin
				k = KIND_UNUSED;
				a = 8'($urandom_range(255));
			end
			offer_item(k, a, d, 1'b0, 8'h00);
			n++;
			counted++;
		end
		in_valid <= 1'b0;

		while (pending_reads.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		leftover = pending_reads.size();
		$display("%0d items sent, %0d reads checked, %0d pops, %0d keys queued, %0d dropped",
			items_sent, reads_checked, pops_done, keys_stored, keys_dropped);
		$display("%0d mismatches, %0d reads left unanswered", mismatches, leftover);
		if (mismatches == 0 && leftover == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
design/cvkb_pkg.sv
design/cvkb_text_mem.sv
design/cvkb_key_queue.sv
design/console_video_and_key_buffer_io_unit.sv
dv/console_video_and_key_buffer_io_unit_test.sv
